### rtl/fbpu_pkg.sv
// ----------------------------------------------------------------------------
// fbpu_pkg
// Types and constants of the flash block write-protection unit.
// ----------------------------------------------------------------------------
package fbpu_pkg;

  // wide enough for offset + length at the largest flash size
  localparam int unsigned ADDR_W = 26;

  localparam int unsigned SEC_SHIFT = 11;   // 2 KiB granule
  localparam int unsigned BLK_SHIFT = 16;   // 64 KiB granule

  localparam logic [ADDR_W-1:0] SZ_4K   = ADDR_W'(4 * 1024);
  localparam logic [ADDR_W-1:0] SZ_32K  = ADDR_W'(32 * 1024);
  localparam logic [ADDR_W-1:0] SZ_128K = ADDR_W'(128 * 1024);

  localparam logic [2:0] EXP_SEC_16    = 3'd5;  // counts as 16 blocks
  localparam logic [2:0] EXP_UNDEFINED = 3'd6;
  localparam logic [ADDR_W-1:0] SEC_16_COUNT = ADDR_W'(1 << 4);

  typedef enum logic [1:0] {
    OP_CHECK = 2'd0,
    OP_SET   = 2'd1,
    OP_LOAD  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    RC_OK      = 2'd0,
    RC_INVALID = 2'd1,
    RC_DENIED  = 2'd2
  } rc_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [23:0] offset;
    logic [23:0] length;
    logic [7:0]  raw_status_one;
    logic [7:0]  raw_status_two;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_code;
    logic [22:0] range_start;
    logic [23:0] range_length;
    logic [6:0]  status_one_bits;
    logic        complement_bit;
  } out_item_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] len;
  } dec_t;

endpackage

### rtl/flash_block_protect_unit.sv
// ----------------------------------------------------------------------------
// flash_block_protect_unit
// Holds SPI NOR block-protection bits; checks accesses, encodes ranges
// into the bits and loads raw status bytes.
// ----------------------------------------------------------------------------
//  channel  | ports                  | handshake
//  ---------+------------------------+-----------------------------------
//  command  | start, busy, in_item   | taken when start && !busy
//  result   | out_valid, out_item    | one-cycle strobe, no backpressure
//
// One transaction per cycle; busy is always low. A command is registered
// in in_r, then decoded and its result registered in out_r. Protection state
// updates in the result stage, so back-to-back commands see the bits left by
// the one before. Reset clears the bits (no protection) and the valid flags.
module flash_block_protect_unit #(
  parameter int unsigned FLASH_BYTES = 8388608
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fbpu_pkg::in_item_t  in_item,
  output logic                out_valid,
  output fbpu_pkg::out_item_t out_item
);

  localparam int unsigned AW = fbpu_pkg::ADDR_W;
  localparam logic [AW-1:0] FB = AW'(FLASH_BYTES);

  function automatic fbpu_pkg::dec_t decode_bits(logic cmp, logic sec, logic bot,
                                                 logic [2:0] ex);
    fbpu_pkg::dec_t d;
    logic [AW-1:0] l;
    logic [AW-1:0] s;
    d.ok = 1'b1;
    d.start = '0;
    d.len = '0;
    if (ex == 3'd0) begin
      l = '0;
    end else if (sec) begin
      if (ex == fbpu_pkg::EXP_SEC_16) begin
        l = fbpu_pkg::SEC_16_COUNT << fbpu_pkg::SEC_SHIFT;
      end else begin
        l = AW'(1) << (fbpu_pkg::SEC_SHIFT + 32'(ex));
      end
    end else begin
      l = AW'(1) << (fbpu_pkg::BLK_SHIFT + 32'(ex));
    end
    if (l > FB) begin
      l = FB;
    end
    s = (bot || l == '0) ? '0 : FB - l;
    if (cmp) begin
      s = (bot && l != FB) ? l : '0;
      l = FB - l;
    end
    if (sec && ex == fbpu_pkg::EXP_UNDEFINED) begin
      d.ok = 1'b0;
    end else begin
      d.start = s;
      d.len = l;
    end
    return d;
  endfunction

  logic                 in_vld_r;
  fbpu_pkg::in_item_t   in_r;
  logic                 cmp_r, sec_r, bot_r;
  logic [2:0]           exp_r;
  logic                 cmp_nxt, sec_nxt, bot_nxt;
  logic [2:0]           exp_nxt;
  logic                 out_valid_r;
  fbpu_pkg::out_item_t  out_r;
  fbpu_pkg::out_item_t  out_nxt;
  fbpu_pkg::rc_t        rc;

  fbpu_pkg::dec_t cur_dec, enc_dec, new_dec;
  logic [AW-1:0]  off_x, len_x, sum, acc_end, lo, hi;
  logic [AW-1:0]  e_s, e_l, blocks;
  logic           e_cmp, e_sec, e_bot, e_bad;
  logic [4:0]     e_exp;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
    in_r <= in_item;
  end

  // check and encode
  always_comb begin
    off_x = AW'(in_r.offset);
    len_x = AW'(in_r.length);
    sum   = off_x + len_x;
    cur_dec = decode_bits(cmp_r, sec_r, bot_r, exp_r);
    acc_end = cur_dec.start + cur_dec.len;
    lo = (cur_dec.start > off_x) ? cur_dec.start : off_x;
    hi = (acc_end < sum) ? acc_end : sum;

    e_bad = (in_r.offset != '0 && in_r.length == '0) || sum > FB;
    if ((in_r.length & (in_r.length - 24'd1)) != '0) begin
      e_cmp = 1'b1;
      e_s = (sum == FB) ? '0 : sum;
      e_l = FB - len_x;
    end else begin
      e_cmp = 1'b0;
      e_s = off_x;
      e_l = len_x;
    end
    e_bot = (e_s == '0) && (e_l != '0) && (e_l != FB);
    e_sec = 1'b0;
    if (e_l == '0 || e_l >= fbpu_pkg::SZ_128K) begin
      e_sec = 1'b0;
    end else if (e_l >= fbpu_pkg::SZ_4K && e_l <= fbpu_pkg::SZ_32K) begin
      e_sec = 1'b1;
    end else begin
      e_bad = 1'b1;
    end
    if (e_sec) begin
      if (e_l[fbpu_pkg::SEC_SHIFT-1:0] != '0) e_bad = 1'b1;
      blocks = e_l >> fbpu_pkg::SEC_SHIFT;
    end else begin
      if (e_l[fbpu_pkg::BLK_SHIFT-1:0] != '0) e_bad = 1'b1;
      blocks = e_l >> fbpu_pkg::BLK_SHIFT;
    end
    e_exp = '0;
    for (int i = 1; i < AW; i++) begin
      if (blocks[i]) e_exp = 5'(i);
    end
    if (e_exp > 5'd7) e_bad = 1'b1;
    enc_dec = decode_bits(e_cmp, e_sec, e_bot, e_exp[2:0]);
    if (!enc_dec.ok || enc_dec.start != off_x || enc_dec.len != len_x) begin
      e_bad = 1'b1;
    end
  end

  always_comb begin
    cmp_nxt = cmp_r;
    sec_nxt = sec_r;
    bot_nxt = bot_r;
    exp_nxt = exp_r;
    rc = fbpu_pkg::RC_INVALID;
    case (in_r.opcode)
      fbpu_pkg::OP_CHECK: begin
        if (sum > FB || !cur_dec.ok) begin
          rc = fbpu_pkg::RC_INVALID;
        end else if (lo < hi) begin
          rc = fbpu_pkg::RC_DENIED;
        end else begin
          rc = fbpu_pkg::RC_OK;
        end
      end
      fbpu_pkg::OP_SET: begin
        if (e_bad) begin
          rc = fbpu_pkg::RC_INVALID;
        end else begin
          rc = fbpu_pkg::RC_OK;
          cmp_nxt = e_cmp;
          sec_nxt = e_sec;
          bot_nxt = e_bot;
          exp_nxt = e_exp[2:0];
        end
      end
      fbpu_pkg::OP_LOAD: begin
        sec_nxt = in_r.raw_status_one[6];
        bot_nxt = in_r.raw_status_one[5];
        exp_nxt = in_r.raw_status_one[4:2];
        cmp_nxt = in_r.raw_status_two[6];
        rc = (sec_nxt && exp_nxt == fbpu_pkg::EXP_UNDEFINED) ?
             fbpu_pkg::RC_INVALID : fbpu_pkg::RC_OK;
      end
      default: begin
        rc = fbpu_pkg::RC_INVALID;
      end
    endcase
    new_dec = decode_bits(cmp_nxt, sec_nxt, bot_nxt, exp_nxt);
    out_nxt.result_code     = rc;
    out_nxt.range_start     = new_dec.start[22:0];
    out_nxt.range_length    = new_dec.len[23:0];
    out_nxt.status_one_bits = {sec_nxt, bot_nxt, exp_nxt, 2'b00};
    out_nxt.complement_bit  = cmp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_r <= 1'b0;
      sec_r <= 1'b0;
      bot_r <= 1'b0;
      exp_r <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_vld_r;
      if (in_vld_r) begin
        cmp_r <= cmp_nxt;
        sec_r <= sec_nxt;
        bot_r <= bot_nxt;
        exp_r <= exp_nxt;
      end
    end
    if (in_vld_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r |=> out_valid_r)
    else $error("command without result");

  a_ok_defined: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.result_code == fbpu_pkg::RC_OK
      |-> !(out_r.status_one_bits[6] &&
            out_r.status_one_bits[4:2] == fbpu_pkg::EXP_UNDEFINED))
    else $error("ok reported with undefined protection bits");

  a_check_keeps_bits: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && in_r.opcode == fbpu_pkg::OP_CHECK
      |=> $stable({cmp_r, sec_r, bot_r, exp_r}))
    else $error("access check changed protection bits");

  a_bits_match_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.status_one_bits == {sec_r, bot_r, exp_r, 2'b00} &&
                    out_r.complement_bit == cmp_r)
    else $error("reported bits differ from held state");

endmodule
